FILE: hw/rtl/psch_pkg.sv
// Shared types, constants and helpers of the process table scheduler.
// No dependencies; the cell, the scheduler and the test files import this package.
`default_nettype none
package psch_pkg;

  localparam int SLOTS      = 64;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W      = 32;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_PICK  = 3'd1;
  localparam logic [2:0] OP_ADMIT = 3'd2;
  localparam logic [2:0] OP_STATE = 3'd3;
  localparam logic [2:0] OP_PRIO  = 3'd4;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_SLEEPING = 3'd1;
  localparam logic [2:0] ST_RUNNABLE = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;
  localparam logic [2:0] ST_ZOMBIE   = 3'd4;

  localparam logic [1:0] MODE_RR   = 2'd0;
  localparam logic [1:0] MODE_FCFS = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;
  localparam logic [1:0] MODE_MLFQ = 2'd3;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_AGING = 2'd1;
  localparam logic [1:0] CFG_DPRIO = 2'd2;

  localparam logic [6:0] PRIO_MAX  = 7'd100;
  localparam logic [2:0] TOP_LEVEL = 3'd4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic                  tick;
    logic                  demote;
    logic                  age;
    logic                  commit;
    logic                  admit;
    logic                  set_state;
    logic                  set_prio;
    logic                  lookup;
    logic [1:0]            mode;
    logic [5:0]            slot;
    logic [IDX_W-1:0]      pick_idx;
    logic [IDX_W-1:0]      rot;
    logic [2:0]            new_state;
    logic [6:0]            new_prio;
    logic [6:0]            admit_prio;
    logic [15:0]           age_limit;
    logic [31:0]           tick_count;
  } psch_cmd_t;

  // Best-so-far candidate handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] pkey;
    logic [KEY_W-1:0] skey;
  } psch_tok_t;

  function automatic logic [COUNT_BITS-1:0] quantum(input logic [2:0] lvl);
    logic [2:0] q;
    q = (lvl > TOP_LEVEL) ? TOP_LEVEL : lvl;
    return COUNT_BITS'(1) << q;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [6:0] sat_prio(input logic [6:0] v);
    return (v > PRIO_MAX) ? PRIO_MAX : v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/psch_if.sv
// Valid/ready channel interfaces: operation input, result output, register writes.
// Depends on nothing but the payload widths of the block.
`default_nettype none
interface psch_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [5:0] slot;
  logic [2:0] new_state;
  logic [6:0] req_prio;
  modport source (output valid, op, slot, new_state, req_prio, input ready);
  modport sink   (input valid, op, slot, new_state, req_prio, output ready);
endinterface

interface psch_out_if;
  logic              valid;
  logic              ready;
  logic              picked;
  logic [5:0]        picked_slot;
  logic signed [7:0] prev_prio;
  modport source (output valid, picked, picked_slot, prev_prio, input ready);
  modport sink   (input valid, picked, picked_slot, prev_prio, output ready);
endinterface

interface psch_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/psch_cell.sv
// One table slot: its counters, level and priority, plus one stage of the
// candidate chain. Depends on psch_pkg.
`default_nettype none
module psch_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [psch_pkg::IDX_W-1:0] cell_idx,
  input  wire psch_pkg::psch_cmd_t     cmd,
  input  wire psch_pkg::psch_tok_t     tok_in,
  output psch_pkg::psch_tok_t          tok_out
);
  import psch_pkg::*;

  logic [2:0]            state_r, state_nxt;
  logic [COUNT_BITS-1:0] wait_r, wait_nxt;
  logic [COUNT_BITS-1:0] run_r, run_nxt;
  logic [2:0]            level_r, level_nxt;
  logic [6:0]            prio_r, prio_nxt;
  logic [31:0]           created_r, created_nxt;
  psch_tok_t             tok_r, tok_nxt;

  logic             hit_slot, hit_pick, runnable;
  logic [KEY_W-1:0] pk, sk;

  assign hit_slot = (32'(cell_idx) == 32'(cmd.slot));
  assign hit_pick = (cell_idx == cmd.pick_idx);
  assign runnable = (state_r == ST_RUNNABLE);

  always_comb begin
    state_nxt   = state_r;
    wait_nxt    = wait_r;
    run_nxt     = run_r;
    level_nxt   = level_r;
    prio_nxt    = prio_r;
    created_nxt = created_r;
    if (cmd.tick) begin
      if (state_r == ST_RUNNING) run_nxt = sat_inc(run_r);
      else if (state_r == ST_SLEEPING) run_nxt = '0;
      else if (runnable) wait_nxt = sat_inc(wait_r);
    end
    if (cmd.demote && runnable && run_r >= quantum(level_r)) begin
      if (level_r < TOP_LEVEL) level_nxt = level_r + 3'd1;
      wait_nxt = '0;
      run_nxt  = '0;
    end
    if (cmd.age && runnable && level_r != 3'd0 &&
        32'(wait_r) > 32'(cmd.age_limit)) begin
      level_nxt = level_r - 3'd1;
      wait_nxt  = '0;
      run_nxt   = '0;
    end
    if (cmd.commit && hit_pick) begin
      state_nxt = ST_RUNNING;
      wait_nxt  = '0;
    end
    if (cmd.admit && hit_slot && state_r == ST_UNUSED) begin
      state_nxt   = ST_RUNNABLE;
      created_nxt = cmd.tick_count;
      wait_nxt    = '0;
      run_nxt     = '0;
      level_nxt   = '0;
      prio_nxt    = cmd.admit_prio;
    end
    if (cmd.set_state && hit_slot && cmd.new_state <= ST_ZOMBIE) state_nxt = cmd.new_state;
    if (cmd.set_prio && hit_slot && state_r != ST_UNUSED) prio_nxt = cmd.new_prio;
  end

  // Sort keys: smaller wins in both fields
  always_comb begin
    case (cmd.mode)
      MODE_RR: begin
        pk = KEY_W'(cell_idx < cmd.rot);
        sk = '0;
      end
      MODE_FCFS: begin
        pk = KEY_W'(~wait_r);
        sk = created_r;
      end
      MODE_PRIO: begin
        pk = KEY_W'(prio_r);
        sk = KEY_W'(~wait_r);
      end
      default: begin
        pk = KEY_W'(level_r);
        sk = KEY_W'(~wait_r);
      end
    endcase
  end

  always_comb begin
    tok_nxt = tok_in;
    if (cmd.lookup) begin
      if (hit_slot && state_r != ST_UNUSED) begin
        tok_nxt.valid = 1'b1;
        tok_nxt.idx   = cell_idx;
        tok_nxt.pkey  = KEY_W'(prio_r);
        tok_nxt.skey  = '0;
      end
    end else if (runnable && (!tok_in.valid || pk < tok_in.pkey ||
                              (pk == tok_in.pkey && sk < tok_in.skey))) begin
      tok_nxt.valid = 1'b1;
      tok_nxt.idx   = cell_idx;
      tok_nxt.pkey  = pk;
      tok_nxt.skey  = sk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_UNUSED;
      wait_r    <= '0;
      run_r     <= '0;
      level_r   <= '0;
      prio_r    <= '0;
      created_r <= '0;
      tok_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      wait_r    <= wait_nxt;
      run_r     <= run_nxt;
      level_r   <= level_nxt;
      prio_r    <= prio_nxt;
      created_r <= created_nxt;
      tok_r     <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

FILE: hw/rtl/process_table_scheduler.sv
// Process table scheduler: operation sequencer, registers and the row of slot cells.
// Depends on psch_pkg, psch_if and psch_cell.
//
// Usage:
//   in_ch carries one operation per transaction (tick, pick, admit, set state,
//   set priority); out_ch returns exactly one result transaction for each.
//   cfg_ch writes mode, aging time and default priority; write it only while
//   no operation is outstanding.
//   Sequence: tick, admit, set state and unknown ops pass through the execute
//   and done states before result valid rises. Set priority and a pick also
//   scan the row and commit, and a pick in multilevel feedback mode first demotes
//   and ages; the candidate walks the row of SLOTS cells one cell per cycle. One
//   operation is in work at a time; the next one can be accepted in the cycle
//   after the result is loaded.
//   The result sits in an output register; the next operation is accepted
//   while it waits, and that one holds in its final state until the receiver
//   takes the earlier result.
//   Reset clears the whole table, the tick count and the rotation pointer and
//   loads mode 3, aging time 30 and default priority 60. No warm-up pass.
`default_nettype none
module process_table_scheduler (
  input  wire logic clk,
  input  wire logic rst_n,
  psch_in_if.sink   in_ch,
  psch_out_if.source out_ch,
  psch_cfg_if.sink  cfg_ch
);
  import psch_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_DEMOTE = 3'd2;
  localparam logic [2:0] S_AGE    = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       op_r;
  logic [5:0]       slot_r;
  logic [2:0]       nst_r;
  logic [6:0]       npr_r;
  logic [1:0]       mode_r;
  logic [15:0]      aging_r;
  logic [6:0]       dprio_r;
  logic [31:0]      tick_r;
  logic [IDX_W-1:0] rot_r;

  logic              res_picked_r;
  logic [5:0]        res_slot_r;
  logic signed [7:0] res_old_r;

  logic              out_valid_r;
  logic              out_picked_r;
  logic [5:0]        out_slot_r;
  logic signed [7:0] out_old_r;

  psch_cmd_t cmd;
  psch_tok_t tok [SLOTS+1];
  psch_tok_t best;

  logic in_fire;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign best         = tok[SLOTS];

  always_comb begin
    cmd            = '0;
    cmd.mode       = mode_r;
    cmd.slot       = slot_r;
    cmd.pick_idx   = best.idx;
    cmd.rot        = rot_r;
    cmd.new_state  = nst_r;
    cmd.new_prio   = sat_prio(npr_r);
    cmd.admit_prio = sat_prio(dprio_r);
    cmd.age_limit  = aging_r;
    cmd.tick_count = tick_r;
    cmd.lookup     = (op_r == OP_PRIO);
    cmd.tick       = (state_r == S_EXEC) && (op_r == OP_TICK);
    cmd.admit      = (state_r == S_EXEC) && (op_r == OP_ADMIT);
    cmd.set_state  = (state_r == S_EXEC) && (op_r == OP_STATE);
    cmd.demote     = (state_r == S_DEMOTE);
    cmd.age        = (state_r == S_AGE);
    cmd.commit     = (state_r == S_COMMIT) && (op_r == OP_PICK) && best.valid;
    cmd.set_prio   = (state_r == S_COMMIT) && (op_r == OP_PRIO);
  end

  assign tok[0] = '0;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    psch_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .cmd      (cmd),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_EXEC;
      S_EXEC: begin
        cnt_nxt = IDX_W'(SLOTS - 1);
        if (op_r == OP_PICK) state_nxt = (mode_r == MODE_MLFQ) ? S_DEMOTE : S_SCAN;
        else if (op_r == OP_PRIO) state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_DEMOTE: state_nxt = S_AGE;
      S_AGE:    state_nxt = S_SCAN;
      S_SCAN: begin
        // let the candidate clear the whole row
        if (cnt_r == '0) state_nxt = S_COMMIT;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_COMMIT: state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mode_r      <= MODE_MLFQ;
      aging_r     <= 16'd30;
      dprio_r     <= 7'd60;
      tick_r      <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MODE:  mode_r  <= cfg_ch.data[1:0];
          CFG_AGING: aging_r <= cfg_ch.data;
          CFG_DPRIO: dprio_r <= cfg_ch.data[6:0];
          default:   ;
        endcase
      end
      if (cmd.tick && tick_r != 32'hFFFF_FFFF) tick_r <= tick_r + 32'd1;
      if (cmd.commit && mode_r == MODE_RR) begin
        rot_r <= (32'(best.idx) == SLOTS - 1) ? '0 : best.idx + 1'b1;
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      else if (state_r == S_DONE) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_ch.op;
      slot_r <= in_ch.slot;
      nst_r  <= in_ch.new_state;
      npr_r  <= in_ch.req_prio;
    end
    if (state_r == S_EXEC) begin
      res_picked_r <= 1'b0;
      res_slot_r   <= '0;
      res_old_r    <= '0;
    end
    if (state_r == S_COMMIT) begin
      if (op_r == OP_PICK) begin
        res_picked_r <= best.valid;
        res_slot_r   <= best.valid ? 6'(best.idx) : 6'd0;
      end else begin
        res_old_r <= best.valid ? $signed({1'b0, best.pkey[6:0]}) : -8'sd1;
      end
    end
    if (state_r == S_DONE && !out_valid_r) begin
      out_picked_r <= res_picked_r;
      out_slot_r   <= res_slot_r;
      out_old_r    <= res_old_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.picked      = out_picked_r;
  assign out_ch.picked_slot = out_slot_r;
  assign out_ch.prev_prio   = out_old_r;

endmodule
`default_nettype wire

FILE: test/psch_test_pkg.sv
// Scheduler predictor for the process table scheduler testbench.
// Depends on psch_pkg for op, state, mode and register codes and the priority and level limits.
`default_nettype none
package psch_test_pkg;
  import psch_pkg::*;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] slot;
    logic [2:0] new_state;
    logic [6:0] req_prio;
  } sched_op_t;

  typedef struct packed {
    logic              picked;
    logic [5:0]        picked_slot;
    logic signed [7:0] prev_prio;
  } sched_res_t;

  localparam logic [15:0] CNT_TOP = 16'hFFFF;

  class sched_predictor;
    logic [1:0]  mode_r;
    logic [15:0] aging_r;
    logic [6:0]  dprio_r;
    logic [2:0]  st[64];
    logic [15:0] wt[64];
    logic [15:0] rt[64];
    logic [2:0]  lv[64];
    logic [6:0]  pr[64];
    logic [31:0] born[64];
    logic [31:0] ticks;
    logic [5:0]  rot;

    function void clear();
      mode_r = MODE_MLFQ;
      aging_r = 16'd30;
      dprio_r = 7'd60;
      for (int i = 0; i < 64; i++) begin
        st[i] = ST_UNUSED; wt[i] = '0; rt[i] = '0; lv[i] = '0; pr[i] = '0; born[i] = '0;
      end
      ticks = '0;
      rot = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_MODE:  mode_r = data[1:0];
        CFG_AGING: aging_r = data;
        CFG_DPRIO: dprio_r = data[6:0];
        default: ;
      endcase
    endfunction

    function int choose_slot();
      int b;
      int s;
      logic [2:0] q;
      b = -1;
      case (mode_r)
        MODE_RR: begin
          for (int i = 0; i < 64; i++) begin
            s = (rot + i) % 64;
            if (st[s] == ST_RUNNABLE) begin
              rot = 6'(s + 1);
              return s;
            end
          end
          return -1;
        end
        MODE_FCFS: begin
          for (int i = 0; i < 64; i++)
            if (st[i] == ST_RUNNABLE &&
                (b < 0 || wt[b] < wt[i] || (wt[b] == wt[i] && born[b] > born[i])))
              b = i;
          return b;
        end
        MODE_PRIO: begin
          for (int i = 0; i < 64; i++)
            if (st[i] == ST_RUNNABLE &&
                (b < 0 || pr[b] > pr[i] || (pr[b] == pr[i] && wt[b] < wt[i])))
              b = i;
          return b;
        end
        default: begin
          for (int i = 0; i < 64; i++) begin
            q = (lv[i] > TOP_LEVEL) ? TOP_LEVEL : lv[i];
            if (st[i] == ST_RUNNABLE && 32'(rt[i]) >= (32'd1 << q)) begin
              if (lv[i] < TOP_LEVEL) lv[i]++;
              wt[i] = '0; rt[i] = '0;
            end
          end
          for (int i = 0; i < 64; i++)
            if (st[i] == ST_RUNNABLE && wt[i] > aging_r && lv[i] != 0) begin
              lv[i]--; wt[i] = '0; rt[i] = '0;
            end
          for (int l = 0; l <= 4 && b < 0; l++)
            for (int i = 0; i < 64; i++)
              if (st[i] == ST_RUNNABLE && lv[i] == l && (b < 0 || wt[b] < wt[i]))
                b = i;
          return b;
        end
      endcase
    endfunction

    function sched_res_t step(sched_op_t t);
      sched_res_t r;
      int s;
      r = '0;
      case (t.op)
        OP_TICK: begin
          if (ticks != '1) ticks++;
          for (int i = 0; i < 64; i++)
            if (st[i] == ST_RUNNING) rt[i] = (rt[i] == CNT_TOP) ? rt[i] : rt[i] + 1'b1;
            else if (st[i] == ST_SLEEPING) rt[i] = '0;
            else if (st[i] == ST_RUNNABLE) wt[i] = (wt[i] == CNT_TOP) ? wt[i] : wt[i] + 1'b1;
        end
        OP_PICK: begin
          s = choose_slot();
          if (s >= 0) begin
            st[s] = ST_RUNNING; wt[s] = '0;
            r.picked = 1'b1; r.picked_slot = 6'(s);
          end
        end
        OP_ADMIT: if (st[t.slot] == ST_UNUSED) begin
          st[t.slot] = ST_RUNNABLE; born[t.slot] = ticks;
          wt[t.slot] = '0; rt[t.slot] = '0; lv[t.slot] = '0;
          pr[t.slot] = (dprio_r > PRIO_MAX) ? PRIO_MAX : dprio_r;
        end
        OP_STATE: if (t.new_state <= ST_ZOMBIE) st[t.slot] = t.new_state;
        OP_PRIO: begin
          if (st[t.slot] != ST_UNUSED) begin
            r.prev_prio = {1'b0, pr[t.slot]};
            pr[t.slot] = (t.req_prio > PRIO_MAX) ? PRIO_MAX : t.req_prio;
          end else begin
            r.prev_prio = -8'sd1;
          end
        end
        default: ;
      endcase
      return r;
    endfunction
  endclass
endpackage
`default_nettype wire

FILE: test/process_table_scheduler_test.sv
// Top testbench for process_table_scheduler: directed table, then random phases.
// Depends on psch_pkg, psch_if, psch_test_pkg and the scheduler RTL.
`default_nettype none
module process_table_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psch_pkg::*;
  import psch_test_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  psch_in_if  in_ch();
  psch_out_if out_ch();
  psch_cfg_if cfg_ch();

  process_table_scheduler dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  sched_predictor model = new();
  sched_res_t results_due[$];
  logic       typed_due[$];
  sched_res_t typed_val[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;

  typedef struct {
    sched_op_t  t;
    logic       typed;
    sched_res_t r;
  } row_t;

  // Directed rows; typed results only where obvious
  row_t rows[] = '{
    '{'{OP_PICK, 6'd0, 3'd0, 7'd0}, 1'b1, '{1'b0, 6'd0, 8'sd0}},
    '{'{OP_PRIO, 6'd63, 3'd0, 7'd5}, 1'b1, '{1'b0, 6'd0, -8'sd1}},
    '{'{OP_ADMIT, 6'd63, 3'd0, 7'd0}, 1'b1, '{1'b0, 6'd0, 8'sd0}},
    '{'{OP_PRIO, 6'd63, 3'd0, 7'd127}, 1'b1, '{1'b0, 6'd0, 8'sd60}},
    '{'{OP_PRIO, 6'd63, 3'd0, 7'd0}, 1'b1, '{1'b0, 6'd0, 8'sd100}},
    '{'{OP_ADMIT, 6'd0, 3'd0, 7'd0}, 1'b0, '0},
    '{'{OP_ADMIT, 6'd0, 3'd0, 7'd0}, 1'b0, '0},
    '{'{OP_TICK, 6'd0, 3'd0, 7'd0}, 1'b0, '0},
    '{'{OP_PICK, 6'd0, 3'd0, 7'd0}, 1'b0, '0},
    '{'{OP_TICK, 6'd0, 3'd0, 7'd0}, 1'b0, '0},
    '{'{OP_TICK, 6'd0, 3'd0, 7'd0}, 1'b0, '0},
    '{'{OP_STATE, 6'd0, ST_RUNNABLE, 7'd0}, 1'b0, '0},
    '{'{OP_PICK, 6'd0, 3'd0, 7'd0}, 1'b0, '0},
    '{'{OP_STATE, 6'd1, 3'd7, 7'd0}, 1'b0, '0},
    '{'{OP_STATE, 6'd1, ST_SLEEPING, 7'd0}, 1'b0, '0},
    '{'{OP_STATE, 6'd2, ST_ZOMBIE, 7'd0}, 1'b0, '0},
    '{'{3'd5, 6'd10, 3'd2, 7'd9}, 1'b1, '{1'b0, 6'd0, 8'sd0}},
    '{'{3'd7, 6'd63, 3'd7, 7'd127}, 1'b1, '{1'b0, 6'd0, 8'sd0}},
    '{'{OP_PICK, 6'd0, 3'd0, 7'd0}, 1'b0, '0},
    '{'{OP_STATE, 6'd0, ST_UNUSED, 7'd0}, 1'b0, '0},
    '{'{OP_PRIO, 6'd0, 3'd0, 7'd1}, 1'b1, '{1'b0, 6'd0, -8'sd1}}
  };

  // Result checking and receiver stalls
  always @(posedge clk) begin
    sched_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_ch.picked);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_ch.picked !== want.picked || out_ch.picked_slot !== want.picked_slot ||
              out_ch.prev_prio !== want.prev_prio) begin
            $display("%0t: expected %0d/%0d/%0d actual %0d/%0d/%0d", $realtime,
                     want.picked, want.picked_slot, want.prev_prio,
                     out_ch.picked, out_ch.picked_slot, out_ch.prev_prio);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_op(sched_op_t t, logic typed, sched_res_t r);
    sched_res_t p;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= t.op;
    in_ch.slot <= t.slot;
    in_ch.new_state <= t.new_state;
    in_ch.req_prio <= t.req_prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = model.step(t);
    if (typed && p !== r) begin
      $display("%0t: typed row disagrees with predictor", $realtime);
      errors++;
    end
    results_due.push_back(typed ? r : p);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    model.write_reg(idx, data);
  endtask

  function automatic sched_op_t rand_op();
    sched_op_t t;
    int k;
    t.slot = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(11));
    t.new_state = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4));
    t.req_prio = ($urandom_range(5) == 0) ? 7'($urandom) : 7'($urandom_range(100));
    k = $urandom_range(99);
    if (k < 35) t.op = OP_TICK;
    else if (k < 60) t.op = OP_PICK;
    else if (k < 72) t.op = OP_ADMIT;
    else if (k < 87) t.op = OP_STATE;
    else if (k < 97) t.op = OP_PRIO;
    else t.op = 3'($urandom_range(7, 5));
    return t;
  endfunction

  initial begin
    logic [1:0]  modes[4];
    logic [15:0] agings[4];
    logic [15:0] dprios[4];
    int idles[4];
    int stalls[4];
    modes = '{MODE_RR, MODE_FCFS, MODE_PRIO, MODE_MLFQ};
    agings = '{16'd0, 16'd65535, 16'd3, 16'd30};
    dprios = '{16'd0, 16'd100, 16'd127, 16'd37};
    idles = '{0, 71, 0, 23};
    stalls = '{0, 0, 71, 23};
    in_ch.valid = 1'b0; in_ch.op = '0; in_ch.slot = '0;
    in_ch.new_state = '0; in_ch.req_prio = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    model.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_op(rows[i].t, rows[i].typed, rows[i].r);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_MODE, 16'(modes[ph % 4]));
      write_reg(CFG_AGING, agings[(ph + 1) % 4]);
      write_reg(CFG_DPRIO, dprios[ph % 4]);
      cfg_ch.valid <= 1'b0;
      send_idle = idles[ph % 4];
      recv_stall = stalls[ph % 4];
      for (int n = 0; n < 220; n++) begin
        if (ph == 2 && n == 20) hold_off = 3000;
        send_op(rand_op(), 1'b0, '0);
      end
      if (ph == 5) drain();
      drain();
    end
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
